// File: rtl/core/spc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg - shared types, constants and helpers
// Word types, config groups, pipeline depths and the fixed-point helpers of
// the straight-alpha pixel compositor.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int FRAC_BITS = 12;
    localparam logic [12:0] ONE_Q = 13'(1 << FRAC_BITS);

    // divider geometry: 29-bit numerator, 13-bit joint alpha, 16-bit quotient
    localparam int DIV_NUM_W  = 29;
    localparam int DIV_DEN_W  = 13;
    localparam int DIV_Q_W    = 16;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = DIV_Q_W / DIV_STEP;

    // stage counts ahead of each divider, and the delay-line lengths built on them
    localparam int BG_PRE      = 3;
    localparam int BG_LINE     = BG_PRE + DIV_STAGES;
    localparam int CLIP_PRE    = 9;
    localparam int CLIP_LINE   = CLIP_PRE + DIV_STAGES;
    localparam int CLIP_CO_LEN = CLIP_PRE - 2;
    localparam int CLIP_JL_LEN = CLIP_PRE - 3 + DIV_STAGES;

    // accept edge to strobe sample edge
    localparam int LATENCY = 1 + (BG_LINE + 1) + (CLIP_LINE + 1) + 1;

    typedef enum logic [2:0] {
        REG_TINT = 3'd0,
        REG_DOP  = 3'd1,
        REG_BRGB = 3'd2,
        REG_BOP  = 3'd3,
        REG_MIX  = 3'd4,
        REG_USE  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [12:0] sample_r;
        logic [12:0] sample_g;
        logic [12:0] sample_b;
        logic [12:0] sample_a;
        logic [7:0]  clip_r;
        logic [7:0]  clip_g;
        logic [7:0]  clip_b;
        logic [7:0]  clip_a;
    } t_in;

    typedef struct packed {
        logic [7:0] out_r;
        logic [7:0] out_g;
        logic [7:0] out_b;
        logic [7:0] out_a;
    } t_out;

    // working pixel: colour index 0..2 = r,g,b; clip index 3 = alpha
    typedef struct packed {
        logic [2:0][15:0] c;
        logic [12:0]      a;
        logic [3:0][7:0]  clip;
    } t_pix;

    typedef struct packed {
        logic [12:0]      ba;
        logic [2:0][12:0] bc;
    } t_bg_cfg;

    typedef struct packed {
        logic        en;
        logic [12:0] mix;
    } t_clip_cfg;

    // exact floor(v / 255) for any 32-bit v
    function automatic logic [24:0] div255(input logic [31:0] v);
        logic [63:0] p;
        p = 64'(v) * 64'h0000_0000_8080_8081;
        return p[63:39];
    endfunction

    function automatic logic [12:0] sat_one(input logic [15:0] v);
        return (v > 16'(ONE_Q)) ? ONE_Q : v[12:0];
    endfunction

    // clamp to one, scale by 255, round
    function automatic logic [7:0] to_byte(input logic [15:0] v);
        logic [12:0] s;
        logic [20:0] t;
        s = sat_one(v);
        t = ({s, 8'b0} - 21'(s)) + 21'(1 << (FRAC_BITS - 1));
        return t[19:12];
    endfunction

endpackage

// File: rtl/core/straight_alpha_pixel_compositor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// straight_alpha_pixel_compositor_unit - per-pixel straight-alpha compositor
// Tints a Q12 drawing sample, puts it over a flat background and optionally
// over a clip pixel, and emits clamped, rounded RGBA bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input word : i_sample, taken at a clock edge with start high and busy low.
//                busy is only high while i_rst_n is low, so one word can be
//                taken every cycle.
//   Output word: o_result, valid for the single cycle o_strobe is high. The
//                receiver cannot stall; every result is delivered once.
//   Flow       : a word runs from the accepting edge through the stages below
//                to the edge that samples o_strobe; one pixel per clock.
//   Depth      : front tint stage, background stage (3 prep stages, 8-stage
//                divider, select), clip stage (9 prep stages, 8-stage divider,
//                select), output byte stage. The radix-4 dividers set the bulk
//                of the latency.
//   Config     : APB, 64-bit data, register i at byte address 8*i. Write only
//                while no pixel is in flight. pready is tied high; reads
//                return the register contents.
//   Reset      : synchronous, active low. Registers return to defaults (unit
//                tint, full opacity and mix, no background, clip off) and all
//                words in flight are dropped.
// ----------------------------------------------------------------------------
module straight_alpha_pixel_compositor_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  spc_pkg::t_in      i_sample,
    output logic              o_strobe,
    output spc_pkg::t_out     o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    // ---------------- configuration registers ----------------
    logic [41:0] r_tint;
    logic [12:0] r_dop;
    logic [38:0] r_brgb;
    logic [12:0] r_bop;
    logic [12:0] r_mix;
    logic        r_use;
    logic        wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tint <= {14'(spc_pkg::ONE_Q), 14'(spc_pkg::ONE_Q), 14'(spc_pkg::ONE_Q)};
            r_dop  <= spc_pkg::ONE_Q;
            r_brgb <= '0;
            r_bop  <= '0;
            r_mix  <= spc_pkg::ONE_Q;
            r_use  <= 1'b0;
        end else if (wr) begin
            unique case (paddr[5:3])
                spc_pkg::REG_TINT: r_tint <= pwdata[41:0];
                spc_pkg::REG_DOP:  r_dop  <= pwdata[12:0];
                spc_pkg::REG_BRGB: r_brgb <= pwdata[38:0];
                spc_pkg::REG_BOP:  r_bop  <= pwdata[12:0];
                spc_pkg::REG_MIX:  r_mix  <= pwdata[12:0];
                spc_pkg::REG_USE:  r_use  <= pwdata[0];
                default: ;  // unmapped slots ignore writes
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            spc_pkg::REG_TINT: prdata = 64'(r_tint);
            spc_pkg::REG_DOP:  prdata = 64'(r_dop);
            spc_pkg::REG_BRGB: prdata = 64'(r_brgb);
            spc_pkg::REG_BOP:  prdata = 64'(r_bop);
            spc_pkg::REG_MIX:  prdata = 64'(r_mix);
            spc_pkg::REG_USE:  prdata = 64'(r_use);
            default:           prdata = '0;
        endcase
    end

    // opacity and mix above one saturate
    spc_pkg::t_bg_cfg   bg_cfg;
    spc_pkg::t_clip_cfg clip_cfg;

    always_comb begin
        bg_cfg.ba = spc_pkg::sat_one(16'(r_bop));
        for (int i = 0; i < 3; i++) begin
            bg_cfg.bc[i] = r_brgb[13*i +: 13];
        end
        clip_cfg.en  = r_use;
        clip_cfg.mix = spc_pkg::sat_one(16'(r_mix));
    end

    // ---------------- front stage: tint and drawing opacity ----------------
    // Pipeline never back-pressures; busy only covers reset.
    assign busy = !i_rst_n;

    logic             accept;
    logic             r_fv;
    spc_pkg::t_pix    r_fpix, n_fpix;
    logic [12:0]      samp [3];
    logic [26:0]      cprod [3];
    logic [25:0]      aprod;

    assign accept = start && !busy;

    always_comb begin
        samp[0] = i_sample.sample_r;
        samp[1] = i_sample.sample_g;
        samp[2] = i_sample.sample_b;
        for (int i = 0; i < 3; i++) begin
            cprod[i]    = 27'(samp[i]) * 27'(r_tint[14*i +: 14]);
            // tinted colour may exceed one; clamped at the output
            n_fpix.c[i] = 16'(cprod[i][26:12]);
        end
        aprod   = 26'(i_sample.sample_a) * 26'(r_dop);
        n_fpix.a = spc_pkg::sat_one(16'(aprod[25:12]));
        n_fpix.clip[0] = i_sample.clip_r;
        n_fpix.clip[1] = i_sample.clip_g;
        n_fpix.clip[2] = i_sample.clip_b;
        n_fpix.clip[3] = i_sample.clip_a;
    end

    always_ff @(posedge i_clk) begin
        r_fpix <= n_fpix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= accept;
        end
    end

    // ---------------- compositing stages ----------------
    logic          bg_vld;
    spc_pkg::t_pix bg_pix;
    logic          cl_vld;
    spc_pkg::t_pix cl_pix;

    spc_bg u_bg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_fv),
        .i_pix   (r_fpix),
        .i_cfg   (bg_cfg),
        .o_vld   (bg_vld),
        .o_pix   (bg_pix)
    );

    spc_clip u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (bg_vld),
        .i_pix   (bg_pix),
        .i_cfg   (clip_cfg),
        .o_vld   (cl_vld),
        .o_pix   (cl_pix)
    );

    // ---------------- output stage: clamp and round to bytes ----------------
    logic          r_ov;
    spc_pkg::t_out r_out, n_out;

    always_comb begin
        n_out.out_r = spc_pkg::to_byte(cl_pix.c[0]);
        n_out.out_g = spc_pkg::to_byte(cl_pix.c[1]);
        n_out.out_b = spc_pkg::to_byte(cl_pix.c[2]);
        n_out.out_a = spc_pkg::to_byte(16'(cl_pix.a));
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= cl_vld;
        end
    end

    assign o_strobe = r_ov;
    assign o_result = r_out;

endmodule

// File: rtl/core/spc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_div - pipelined restoring divider
// Two quotient bits per stage; quotient must fit 16 bits when den is nonzero.
// ----------------------------------------------------------------------------
module spc_div (
    input  logic                              i_clk,
    input  logic [spc_pkg::DIV_NUM_W-1:0]     i_num,
    input  logic [spc_pkg::DIV_DEN_W-1:0]     i_den,
    output logic [spc_pkg::DIV_Q_W-1:0]       o_quo
);

    logic [spc_pkg::DIV_NUM_W-1:0] r_rem [spc_pkg::DIV_STAGES];
    logic [spc_pkg::DIV_DEN_W-1:0] r_den [spc_pkg::DIV_STAGES];
    logic [spc_pkg::DIV_Q_W-1:0]   r_quo [spc_pkg::DIV_STAGES];
    logic [spc_pkg::DIV_NUM_W-1:0] n_rem [spc_pkg::DIV_STAGES];
    logic [spc_pkg::DIV_DEN_W-1:0] n_den [spc_pkg::DIV_STAGES];
    logic [spc_pkg::DIV_Q_W-1:0]   n_quo [spc_pkg::DIV_STAGES];

    always_comb begin
        logic [spc_pkg::DIV_NUM_W-1:0] rem;
        logic [spc_pkg::DIV_NUM_W-1:0] sh;
        logic [spc_pkg::DIV_Q_W-1:0]   quo;
        logic [spc_pkg::DIV_DEN_W-1:0] den;
        for (int s = 0; s < spc_pkg::DIV_STAGES; s++) begin
            if (s == 0) begin
                rem = i_num;
                den = i_den;
                quo = '0;
            end else begin
                rem = r_rem[s-1];
                den = r_den[s-1];
                quo = r_quo[s-1];
            end
            for (int j = 0; j < spc_pkg::DIV_STEP; j++) begin
                sh = spc_pkg::DIV_NUM_W'(den) << (spc_pkg::DIV_Q_W - 1 - s * spc_pkg::DIV_STEP - j);
                if (rem >= sh) begin
                    rem = rem - sh;
                    quo[spc_pkg::DIV_Q_W - 1 - s * spc_pkg::DIV_STEP - j] = 1'b1;
                end
            end
            n_rem[s] = rem;
            n_den[s] = den;
            n_quo[s] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < spc_pkg::DIV_STAGES; s++) begin
            r_rem[s] <= n_rem[s];
            r_den[s] <= n_den[s];
            r_quo[s] <= n_quo[s];
        end
    end

    assign o_quo = r_quo[spc_pkg::DIV_STAGES-1];

endmodule

// File: rtl/core/spc_bg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_bg - drawing over flat background
// Straight-alpha over against the background colour; bypassed when the
// background alpha is zero.
// ----------------------------------------------------------------------------
module spc_bg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  spc_pkg::t_pix     i_pix,
    input  spc_pkg::t_bg_cfg  i_cfg,
    output logic              o_vld,
    output spc_pkg::t_pix     o_pix
);

    spc_pkg::t_pix r_line [spc_pkg::BG_LINE];
    logic          r_vl   [spc_pkg::BG_LINE];
    logic [12:0]   r_jl   [spc_pkg::DIV_STAGES];

    logic [24:0]      r1_bk, n1_bk;
    logic [2:0][28:0] r1_ca, n1_ca;
    logic [12:0]      n1_k;
    logic [2:0][28:0] r2_ca;
    logic [2:0][25:0] r2_bt, n2_bt;
    logic [12:0]      r2_joint, n2_joint;
    logic [2:0][28:0] r3_num, n3_num;
    logic [12:0]      r3_joint;
    logic [2:0][15:0] quo;
    logic [37:0]      bt_full [3];

    logic             r_ov;
    spc_pkg::t_pix    r_opix, n_opix;
    logic [12:0]      jl_last;

    always_comb begin
        n1_k  = spc_pkg::ONE_Q - i_pix.a;
        n1_bk = 25'(i_cfg.ba) * 25'(n1_k);
        for (int i = 0; i < 3; i++) begin
            n1_ca[i] = 29'(i_pix.c[i]) * 29'(i_pix.a);
        end
    end

    always_comb begin
        n2_joint = 13'(14'(r_line[0].a) + 14'(r1_bk[24:12]));
        for (int i = 0; i < 3; i++) begin
            bt_full[i] = 38'(i_cfg.bc[i]) * 38'(r1_bk);
            n2_bt[i]   = bt_full[i][37:12];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_num[i] = r2_ca[i] + 29'(r2_bt[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r1_bk    <= n1_bk;
        r1_ca    <= n1_ca;
        r2_ca    <= r1_ca;
        r2_bt    <= n2_bt;
        r2_joint <= n2_joint;
        r3_num   <= n3_num;
        r3_joint <= r2_joint;
        r_line[0] <= i_pix;
        for (int s = 1; s < spc_pkg::BG_LINE; s++) begin
            r_line[s] <= r_line[s-1];
        end
        r_jl[0] <= r3_joint;
        for (int s = 1; s < spc_pkg::DIV_STAGES; s++) begin
            r_jl[s] <= r_jl[s-1];
        end
        r_opix <= n_opix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < spc_pkg::BG_LINE; s++) begin
                r_vl[s] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else begin
            r_vl[0] <= i_vld;
            for (int s = 1; s < spc_pkg::BG_LINE; s++) begin
                r_vl[s] <= r_vl[s-1];
            end
            r_ov <= r_vl[spc_pkg::BG_LINE-1];
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_div
        spc_div u_div (
            .i_clk (i_clk),
            .i_num (r3_num[g]),
            .i_den (r3_joint),
            .o_quo (quo[g])
        );
    end

    assign jl_last = r_jl[spc_pkg::DIV_STAGES-1];

    always_comb begin
        n_opix = r_line[spc_pkg::BG_LINE-1];
        if (i_cfg.ba != '0) begin
            n_opix.a = jl_last;
            if (jl_last != '0) begin
                n_opix.c = quo;
            end
        end
    end

    assign o_vld = r_ov;
    assign o_pix = r_opix;

endmodule

// File: rtl/core/spc_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_clip - drawing over clip pixel
// Mix-scaled drawing alpha, straight-alpha over against the clip bytes;
// the /255 and /65025 terms use reciprocal multiplies.
// ----------------------------------------------------------------------------
module spc_clip (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  spc_pkg::t_pix       i_pix,
    input  spc_pkg::t_clip_cfg  i_cfg,
    output logic                o_vld,
    output spc_pkg::t_pix       o_pix
);

    spc_pkg::t_pix    r_line [spc_pkg::CLIP_LINE];
    logic             r_vl   [spc_pkg::CLIP_LINE];
    logic [12:0]      r_jl   [spc_pkg::CLIP_JL_LEN];
    logic [2:0][28:0] r_co   [spc_pkg::CLIP_CO_LEN];

    logic [25:0]      o_full;
    logic [12:0]      r1_o, n1_o;
    logic [12:0]      n2_k;
    logic [19:0]      r2_p, n2_p;
    logic [2:0][28:0] n2_co;
    logic [12:0]      r2_o;
    logic [12:0]      r3_j, n3_j;
    logic [2:0][27:0] r3_x, n3_x;
    logic [12:0]      r3_o;
    logic [12:0]      n4_joint;
    logic [2:0][27:0] r4_x;
    logic [2:0][19:0] r4_q1, n4_q1;
    logic [2:0][7:0]  r5_r, n5_r;
    logic [2:0][19:0] r5_q1;
    logic [2:0][11:0] r6_u, n6_u;
    logic [2:0][19:0] r6_q1;
    logic [2:0][31:0] r7_z, n7_z;
    logic [2:0][24:0] r8_t, n8_t;
    logic [2:0][28:0] r9_num, n9_num;
    logic [2:0][15:0] quo;

    logic             r_ov;
    spc_pkg::t_pix    r_opix, n_opix;
    logic [12:0]      jl_last;

    always_comb begin
        // drawing alpha times mix
        o_full = 26'(i_pix.a) * 26'(i_cfg.mix);
        n1_o   = 13'(o_full[25:12]);
        // clip alpha times remaining coverage
        n2_k = spc_pkg::ONE_Q - r1_o;
        n2_p = 20'(r_line[0].clip[3]) * 20'(n2_k);
        for (int i = 0; i < 3; i++) begin
            n2_co[i] = 29'(r_line[0].c[i]) * 29'(r1_o);
        end
        n3_j = 13'(spc_pkg::div255(32'(r2_p)));
        for (int i = 0; i < 3; i++) begin
            n3_x[i] = 28'(r_line[1].clip[i]) * 28'(r2_p);
        end
        n4_joint = 13'(14'(r3_o) + 14'(r3_j));
        for (int i = 0; i < 3; i++) begin
            n4_q1[i] = 20'(spc_pkg::div255(32'(r3_x[i])));
            // x*4096/65025 = (q1*4096 + r*4096/255) / 255, q1 = x/255
            n5_r[i]  = 8'(r4_x[i] - ((28'(r4_q1[i]) << 8) - 28'(r4_q1[i])));
            n6_u[i]  = 12'(spc_pkg::div255(32'(r5_r[i]) << 12));
            n7_z[i]  = (32'(r6_q1[i]) << 12) + 32'(r6_u[i]);
            n8_t[i]  = spc_pkg::div255(r7_z[i]);
            n9_num[i] = r_co[spc_pkg::CLIP_CO_LEN-1][i] + 29'(r8_t[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r1_o   <= n1_o;
        r2_p   <= n2_p;
        r2_o   <= r1_o;
        r3_j   <= n3_j;
        r3_x   <= n3_x;
        r3_o   <= r2_o;
        r4_x   <= r3_x;
        r4_q1  <= n4_q1;
        r5_r   <= n5_r;
        r5_q1  <= r4_q1;
        r6_u   <= n6_u;
        r6_q1  <= r5_q1;
        r7_z   <= n7_z;
        r8_t   <= n8_t;
        r9_num <= n9_num;
        r_co[0] <= n2_co;
        for (int s = 1; s < spc_pkg::CLIP_CO_LEN; s++) begin
            r_co[s] <= r_co[s-1];
        end
        r_line[0] <= i_pix;
        for (int s = 1; s < spc_pkg::CLIP_LINE; s++) begin
            r_line[s] <= r_line[s-1];
        end
        r_jl[0] <= n4_joint;
        for (int s = 1; s < spc_pkg::CLIP_JL_LEN; s++) begin
            r_jl[s] <= r_jl[s-1];
        end
        r_opix <= n_opix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < spc_pkg::CLIP_LINE; s++) begin
                r_vl[s] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else begin
            r_vl[0] <= i_vld;
            for (int s = 1; s < spc_pkg::CLIP_LINE; s++) begin
                r_vl[s] <= r_vl[s-1];
            end
            r_ov <= r_vl[spc_pkg::CLIP_LINE-1];
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_div
        spc_div u_div (
            .i_clk (i_clk),
            .i_num (r9_num[g]),
            .i_den (r_jl[spc_pkg::CLIP_PRE-4]),
            .o_quo (quo[g])
        );
    end

    assign jl_last = r_jl[spc_pkg::CLIP_JL_LEN-1];

    always_comb begin
        n_opix = r_line[spc_pkg::CLIP_LINE-1];
        if (i_cfg.en) begin
            n_opix.a = jl_last;
            if (jl_last != '0) begin
                n_opix.c = quo;
            end
        end
    end

    assign o_vld = r_ov;
    assign o_pix = r_opix;

endmodule

// File: rtl/core/spc_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_chk - port-level checker
// Watches handshake timing of the compositor from its ports.
// ----------------------------------------------------------------------------
module spc_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input logic pready
);

    // every accepted word comes out after the fixed latency
    a_acc_to_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(spc_pkg::LATENCY) o_strobe)
        else $error("accepted word did not emerge on time");

    // no result without a matching accept
    a_strobe_has_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, spc_pkg::LATENCY))
        else $error("result without accepted word");

    // reset flushes the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe right after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind straight_alpha_pixel_compositor_unit spc_chk u_chk (.*);
